// ===== rtl/bbfh_pkg.sv =====
// bbfh_pkg: shared types and constants for the band fingerprint hash block
// no dependencies
package bbfh_pkg;

    typedef struct packed {
        logic [31:0] band_energy;
        logic        new_clip;
    } bbfh_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] hash_word;
        logic [4:0]  toggle_index;
        logic [31:0] min_energy;
        logic [31:0] max_energy;
        logic        last;
    } bbfh_out_t;

    localparam logic KIND_HASH   = 1'b0;
    localparam logic KIND_TOGGLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SORT,
        ST_SWAP,
        ST_EMIT
    } bbfh_state_t;

endpackage

// ===== rtl/bbfh_front.sv =====
// bbfh_front: accepts band energies, tracks clip min and max, stores the frame
// and hands a frame-done job to the back engine; depends on bbfh_pkg
module bbfh_front #(
    parameter int NUM_BANDS   = 33,
    parameter int ENERGY_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbfh_pkg::bbfh_in_t            in_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic                          job_valid,
    input  logic                          job_stall,
    output logic [31:0]                   job_min,
    output logic [31:0]                   job_max,
    output logic                          job_first,
    output logic [NUM_BANDS*ENERGY_BITS-1:0] job_energies
);
    import bbfh_pkg::*;

    localparam int CW = $clog2(NUM_BANDS + 1);

    logic [CW-1:0]          cnt_reg;
    logic [ENERGY_BITS-1:0] min_reg, max_reg;
    logic                   first_reg;
    logic [ENERGY_BITS-1:0] en_reg [NUM_BANDS];
    logic                   hold_reg;
    logic [31:0]            jmin_reg, jmax_reg;
    logic                   jfirst_reg;
    logic [ENERGY_BITS-1:0] jen_reg [NUM_BANDS];

    logic                   acc;
    logic [ENERGY_BITS-1:0] e;
    logic [CW-1:0]          idx;
    logic [ENERGY_BITS-1:0] mn, mx;
    logic                   fst;

    assign in_stall = hold_reg;
    assign acc      = in_valid && !hold_reg;
    assign e        = ENERGY_BITS'(in_data.band_energy);

    always_comb
    begin
        idx = in_data.new_clip ? '0 : cnt_reg;
        mn  = in_data.new_clip ? '1 : min_reg;
        mx  = in_data.new_clip ? '0 : max_reg;
        fst = in_data.new_clip ? 1'b1 : first_reg;
        if (e < mn)
        begin
            mn = e;
        end
        if (e > mx)
        begin
            mx = e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            first_reg <= 1'b1;
            hold_reg  <= 1'b0;
        end
        else
        begin
            if (hold_reg && !job_stall)
            begin
                hold_reg <= 1'b0;
            end
            if (acc)
            begin
                min_reg <= mn;
                max_reg <= mx;
                if (idx == CW'(NUM_BANDS - 1))
                begin
                    cnt_reg   <= '0;
                    first_reg <= 1'b0;
                    hold_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg   <= idx + 1'b1;
                    first_reg <= fst;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            en_reg[idx[$clog2(NUM_BANDS)-1:0]] <= e;
            if (idx == CW'(NUM_BANDS - 1))
            begin
                jmin_reg   <= 32'(mn);
                jmax_reg   <= 32'(mx);
                jfirst_reg <= fst;
                for (int i = 0; i < NUM_BANDS - 1; i++)
                begin
                    jen_reg[i] <= en_reg[i];
                end
                jen_reg[NUM_BANDS-1] <= e;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BANDS; i++)
        begin
            job_energies[i*ENERGY_BITS +: ENERGY_BITS] = jen_reg[i];
        end
    end

    assign job_valid = hold_reg;
    assign job_min   = jmin_reg;
    assign job_max   = jmax_reg;
    assign job_first = jfirst_reg;

endmodule

// ===== rtl/bbfh_back.sv =====
// bbfh_back: computes differences and hash, sorts pairs and emits results
// depends on bbfh_pkg
module bbfh_back #(
    parameter int NUM_BANDS   = 33,
    parameter int ENERGY_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [5:0]                    toggle_count,
    input  logic                          job_valid,
    output logic                          job_stall,
    input  logic [31:0]                   job_min,
    input  logic [31:0]                   job_max,
    input  logic                          job_first,
    input  logic [NUM_BANDS*ENERGY_BITS-1:0] job_energies,
    output bbfh_pkg::bbfh_out_t           out_data,
    output logic                          out_valid,
    input  logic                          out_stall
);
    import bbfh_pkg::*;

    localparam int NP = NUM_BANDS - 1;
    localparam int PW = $clog2(NP);
    localparam int CW = $clog2(NP + 1);
    localparam int VW = ENERGY_BITS + 3;

    bbfh_state_t st_reg, st_next;
    logic signed [ENERGY_BITS:0] prior_reg [NP];
    logic signed [VW-1:0]        val_reg [NP];
    logic [4:0]                  ix_reg [NP];
    logic [31:0]                 hash_reg, min_reg, max_reg;
    logic [CW-1:0]               i_reg, j_reg, lo_reg, k_reg, n_reg;
    logic                        ov_reg;
    bbfh_out_t                   od_reg;

    logic out_free, emit_ok;
    logic [CW-1:0] ntog;
    logic signed [ENERGY_BITS:0] d_c [NP];
    logic signed [VW-1:0]        h_c [NP];
    logic [31:0]                 hash_c;

    assign out_free = !ov_reg || !out_stall;
    assign ntog = (toggle_count > 6'(NP)) ? CW'(NP) : CW'(toggle_count);

    // band differences, frame-to-frame differences and hash bits
    always_comb
    begin
        hash_c = '0;
        for (int m = 0; m < NP; m++)
        begin
            d_c[m] = $signed({1'b0, job_energies[m*ENERGY_BITS +: ENERGY_BITS]})
                   - $signed({1'b0, job_energies[(m+1)*ENERGY_BITS +: ENERGY_BITS]});
            h_c[m] = job_first ? VW'(d_c[m]) : VW'(d_c[m]) - VW'(prior_reg[m]);
            hash_c[NP-1-m] = (h_c[m] > 0);
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (job_valid)
                begin
                    st_next = ST_DIFF;
                end
            ST_DIFF:
                st_next = ST_SORT;
            ST_SORT:
                if (j_reg == CW'(NP - 1))
                begin
                    st_next = ST_SWAP;
                end
            ST_SWAP:
                st_next = (i_reg == CW'(NP - 2)) ? ST_EMIT : ST_SORT;
            ST_EMIT:
                if (out_free && k_reg == n_reg)
                begin
                    st_next = ST_IDLE;
                end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_stall = (st_reg != ST_IDLE);
        emit_ok   = (st_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (emit_ok)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                min_reg <= job_min;
                max_reg <= job_max;
                n_reg   <= ntog;
            end
            ST_DIFF:
            begin
                hash_reg <= hash_c;
                for (int m = 0; m < NP; m++)
                begin
                    prior_reg[m] <= d_c[m];
                    val_reg[m]   <= h_c[m];
                    ix_reg[m]    <= 5'(m);
                end
                i_reg  <= '0;
                j_reg  <= CW'(1);
                lo_reg <= '0;
                k_reg  <= '0;
            end
            ST_SORT:
            begin
                if (val_reg[j_reg[PW-1:0]] < val_reg[lo_reg[PW-1:0]])
                begin
                    lo_reg <= j_reg;
                end
                if (j_reg != CW'(NP - 1))
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_SWAP:
            begin
                if (lo_reg != i_reg)
                begin
                    val_reg[i_reg[PW-1:0]]  <= val_reg[lo_reg[PW-1:0]];
                    ix_reg[i_reg[PW-1:0]]   <= ix_reg[lo_reg[PW-1:0]];
                    val_reg[lo_reg[PW-1:0]] <= val_reg[i_reg[PW-1:0]];
                    ix_reg[lo_reg[PW-1:0]]  <= ix_reg[i_reg[PW-1:0]];
                end
                i_reg  <= i_reg + 1'b1;
                lo_reg <= i_reg + 1'b1;
                j_reg  <= i_reg + CW'(2);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    od_reg <= '{
                        kind:         (k_reg == '0) ? KIND_HASH : KIND_TOGGLE,
                        hash_word:    hash_reg,
                        toggle_index: (k_reg == '0) ? 5'd0 : ix_reg[PW'(k_reg - 1'b1)],
                        min_energy:   min_reg,
                        max_energy:   max_reg,
                        last:         (k_reg == n_reg)
                    };
                    k_reg <= k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

// ===== rtl/bark_band_fingerprint_hash.sv =====
// bark_band_fingerprint_hash: top level, front accept stage plus back hash and sort engine
// depends on bbfh_pkg, bbfh_front, bbfh_back
// Bands are taken one per cycle while in_stall is low; after the last band of a frame the
// input stalls while the frame is handed to the back engine. From that hand-off the engine
// computes the differences and runs the selection sort, then emits one result per cycle
// (toggle count + 1 results) while the output is not stalled; the front takes the next
// frame's bands meanwhile and stalls after that frame's last band until the engine has
// emitted its last result.
module bark_band_fingerprint_hash #(
    parameter int NUM_BANDS   = 33,
    parameter int ENERGY_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_data,
    input  bbfh_pkg::bbfh_in_t   in_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    output bbfh_pkg::bbfh_out_t  out_data,
    output logic                 out_valid,
    input  logic                 out_stall
);
    import bbfh_pkg::*;

    logic [5:0]  tc_reg;
    logic        job_valid, job_stall, job_first;
    logic [31:0] job_min, job_max;
    logic [NUM_BANDS*ENERGY_BITS-1:0] job_energies;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
        end
        else if (cfg_we)
        begin
            tc_reg <= cfg_data;
        end
    end

    bbfh_front #(.NUM_BANDS(NUM_BANDS), .ENERGY_BITS(ENERGY_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .job_valid(job_valid), .job_stall(job_stall),
        .job_min(job_min), .job_max(job_max), .job_first(job_first),
        .job_energies(job_energies)
    );

    bbfh_back #(.NUM_BANDS(NUM_BANDS), .ENERGY_BITS(ENERGY_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .toggle_count(tc_reg), .job_valid(job_valid),
        .job_stall(job_stall), .job_min(job_min), .job_max(job_max),
        .job_first(job_first), .job_energies(job_energies), .out_data(out_data),
        .out_valid(out_valid), .out_stall(out_stall)
    );

endmodule
